// ===== design/tahr_pkg.sv =====
// ----------------------------------------------------------------------------
// tahr_pkg
// shared types and constants of the triggered attack/hold/release envelope
// ----------------------------------------------------------------------------
package tahr_pkg;

  localparam int TIME_W    = 22;
  localparam int DELTA_W   = 16;
  localparam int EVENT_W   = 16;
  localparam int MAX_STEPS = 4;
  localparam int STEP_W    = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [TIME_W-1:0] ATTACK_RST  = 22'd3277;
  localparam logic [TIME_W-1:0] HOLD_RST    = 22'd0;
  localparam logic [TIME_W-1:0] RELEASE_RST = 22'd39322;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_HOLD    = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_NEED,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic seg_jump;
    logic hold_step;
    logic mul_load;
    logic need_apply;
    logic div_start;
    logic div_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   trig;
    logic   rem_zero;
    logic   steps_done;
    logic   attack_zero;
    logic   release_zero;
    logic   rem_ge_need;
    logic   div_done;
  } status_t;

endpackage

// ===== design/tahr_div.sv =====
// ----------------------------------------------------------------------------
// tahr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tahr_div #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] part_r, part_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {part_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    part_nxt = part_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dvd_nxt  = dividend;
      q_nxt    = '0;
      part_nxt = '0;
      dvs_nxt  = divisor;
    end else if (run_r) begin
      part_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      q_nxt    = {q_r[DVD_W-2:0], ge};
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    part_r <= part_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== design/tahr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tahr_ctrl
// sequencer: walks the phase segments of one tick and hands off the result
// ----------------------------------------------------------------------------
module tahr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tahr_pkg::status_t st,
  output tahr_pkg::cmd_t    cmd
);

  tahr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             loop_end;
  logic             out_free;

  assign loop_end = st.steps_done || st.rem_zero || (st.phase == tahr_pkg::PH_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tahr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tahr_pkg::ST_EVAL;
      end
      tahr_pkg::ST_EVAL: begin
        if (loop_end) begin
          state_nxt = tahr_pkg::ST_DONE;
        end else begin
          unique case (st.phase)
            tahr_pkg::PH_ATTACK:  state_nxt = st.attack_zero ? tahr_pkg::ST_EVAL
                                                             : tahr_pkg::ST_NEED;
            tahr_pkg::PH_HOLD:    state_nxt = st.trig ? tahr_pkg::ST_DONE
                                                      : tahr_pkg::ST_EVAL;
            tahr_pkg::PH_RELEASE: state_nxt = st.release_zero ? tahr_pkg::ST_EVAL
                                                              : tahr_pkg::ST_NEED;
            default:              state_nxt = tahr_pkg::ST_DONE;
          endcase
        end
      end
      tahr_pkg::ST_NEED: begin
        state_nxt = st.rem_ge_need ? tahr_pkg::ST_EVAL : tahr_pkg::ST_DIV;
      end
      tahr_pkg::ST_DIV: begin
        if (st.div_done) state_nxt = tahr_pkg::ST_EVAL;
      end
      tahr_pkg::ST_DONE: begin
        if (out_free) state_nxt = tahr_pkg::ST_IDLE;
      end
      default: state_nxt = tahr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      tahr_pkg::ST_IDLE: cmd.load = in_valid;
      tahr_pkg::ST_EVAL: begin
        if (!loop_end) begin
          unique case (st.phase)
            tahr_pkg::PH_ATTACK: begin
              cmd.seg_jump = st.attack_zero;
              cmd.mul_load = !st.attack_zero;
            end
            tahr_pkg::PH_HOLD:    cmd.hold_step = !st.trig;
            tahr_pkg::PH_RELEASE: begin
              cmd.seg_jump = st.release_zero;
              cmd.mul_load = !st.release_zero;
            end
            default: ;
          endcase
        end
      end
      tahr_pkg::ST_NEED: begin
        cmd.need_apply = st.rem_ge_need;
        cmd.div_start  = !st.rem_ge_need;
      end
      tahr_pkg::ST_DIV:  cmd.div_apply = st.div_done;
      tahr_pkg::ST_DONE: cmd.out_load  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tahr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != tahr_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ===== design/tahr_dp.sv =====
// ----------------------------------------------------------------------------
// tahr_dp
// envelope state, segment arithmetic, divider and result register
// ----------------------------------------------------------------------------
module tahr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tahr_pkg::cmd_t               cmd,
  output tahr_pkg::status_t            st,
  input  logic [tahr_pkg::TIME_W-1:0]  attack_time,
  input  logic [tahr_pkg::TIME_W-1:0]  hold_time,
  input  logic [tahr_pkg::TIME_W-1:0]  release_time,
  input  logic [tahr_pkg::DELTA_W-1:0] tick_delta,
  input  logic                         event_valid,
  input  logic [tahr_pkg::EVENT_W-1:0] event_id,
  output logic [FRAC_BITS:0]           envelope_level,
  output logic [1:0]                   envelope_phase
);

  localparam int TW        = tahr_pkg::TIME_W;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int REM_W     = FRAC_BITS - 1;
  localparam int PROD_W    = LVL_W + TW;
  localparam int NEED_W    = PROD_W - FRAC_BITS;
  localparam int DVD_W     = REM_W + FRAC_BITS;
  localparam int CMP_W     = (REM_W > TW) ? REM_W : TW;
  localparam int DELTA_MIN = (1 << FRAC_BITS) / 120;
  localparam int DELTA_MAX = (1 << FRAC_BITS) / 4;
  localparam logic [LVL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  tahr_pkg::phase_t             phase_r, phase_nxt;
  logic [LVL_W-1:0]             level_r, level_nxt;
  logic [TW-1:0]                hold_left_r, hold_left_nxt;
  logic [tahr_pkg::EVENT_W-1:0] last_event_r, last_event_nxt;
  logic                         event_seen_r, event_seen_nxt;
  logic                         trig_r, trig_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [tahr_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [PROD_W-1:0]            prod_r;
  logic [LVL_W-1:0]             out_level_r;
  tahr_pkg::phase_t             out_phase_r;

  logic [31:0]       delta_ext;
  logic [REM_W-1:0]  rem_ld;
  logic              trig_ld;
  logic [LVL_W-1:0]  mul_a;
  logic [TW-1:0]     mul_b;
  logic [NEED_W-1:0] need;
  logic [CMP_W-1:0]  used;
  logic [LVL_W-1:0]  headroom;
  logic              div_done;
  logic [DVD_W-1:0]  quot;

  assign delta_ext = 32'(tick_delta);
  always_comb begin
    if (delta_ext < 32'(DELTA_MIN)) rem_ld = REM_W'(DELTA_MIN);
    else if (delta_ext > 32'(DELTA_MAX)) rem_ld = REM_W'(DELTA_MAX);
    else rem_ld = REM_W'(delta_ext);
  end

  assign trig_ld  = event_valid && (!event_seen_r || (event_id != last_event_r));
  assign mul_a    = (phase_r == tahr_pkg::PH_ATTACK) ? ONE - level_r : level_r;
  assign mul_b    = (phase_r == tahr_pkg::PH_ATTACK) ? attack_time : release_time;
  assign need     = prod_r[PROD_W-1:FRAC_BITS];
  assign used     = (CMP_W'(rem_r) < CMP_W'(hold_left_r)) ? CMP_W'(rem_r)
                                                          : CMP_W'(hold_left_r);
  assign headroom = ONE - level_r;

  tahr_div #(
    .DVD_W (DVD_W),
    .DVS_W (TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({rem_r, {FRAC_BITS{1'b0}}}),
    .divisor  (mul_b),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    phase_nxt      = phase_r;
    level_nxt      = level_r;
    hold_left_nxt  = hold_left_r;
    last_event_nxt = last_event_r;
    event_seen_nxt = event_seen_r;
    trig_nxt       = trig_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    if (cmd.seg_jump || cmd.hold_step || cmd.need_apply || cmd.div_apply) begin
      step_nxt = step_r + tahr_pkg::STEP_W'(1);
    end
    if (cmd.load) begin
      rem_nxt  = rem_ld;
      trig_nxt = trig_ld;
      step_nxt = '0;
      if (trig_ld) begin
        last_event_nxt = event_id;
        event_seen_nxt = 1'b1;
        phase_nxt      = tahr_pkg::PH_ATTACK;
        hold_left_nxt  = hold_time;
      end
    end
    if (cmd.seg_jump || cmd.need_apply) begin
      if (phase_r == tahr_pkg::PH_ATTACK) begin
        level_nxt = ONE;
        phase_nxt = tahr_pkg::PH_HOLD;
        if (cmd.need_apply) rem_nxt = REM_W'(NEED_W'(rem_r) - need);
      end else begin
        level_nxt = '0;
        phase_nxt = tahr_pkg::PH_IDLE;
        if (cmd.need_apply) rem_nxt = '0;
      end
    end
    if (cmd.hold_step) begin
      hold_left_nxt = TW'(CMP_W'(hold_left_r) - used);
      rem_nxt       = REM_W'(CMP_W'(rem_r) - used);
      if (CMP_W'(hold_left_r) == used) phase_nxt = tahr_pkg::PH_RELEASE;
    end
    if (cmd.div_apply) begin
      rem_nxt = '0;
      if (phase_r == tahr_pkg::PH_ATTACK) begin
        level_nxt = (quot >= DVD_W'(headroom)) ? ONE : level_r + LVL_W'(quot);
      end else begin
        level_nxt = (DVD_W'(level_r) > quot) ? level_r - LVL_W'(quot) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tahr_pkg::PH_IDLE;
      level_r      <= '0;
      hold_left_r  <= '0;
      last_event_r <= '0;
      event_seen_r <= 1'b0;
      trig_r       <= 1'b0;
      step_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      level_r      <= level_nxt;
      hold_left_r  <= hold_left_nxt;
      last_event_r <= last_event_nxt;
      event_seen_r <= event_seen_nxt;
      trig_r       <= trig_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (cmd.mul_load) prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.out_load) begin
      out_level_r <= (phase_r == tahr_pkg::PH_IDLE) ? '0 : level_r;
      out_phase_r <= phase_r;
    end
  end

  always_comb begin
    st              = '0;
    st.phase        = phase_r;
    st.trig         = trig_r;
    st.rem_zero     = rem_r == '0;
    st.steps_done   = step_r == tahr_pkg::STEP_W'(tahr_pkg::MAX_STEPS);
    st.attack_zero  = attack_time == '0;
    st.release_zero = release_time == '0;
    st.rem_ge_need  = NEED_W'(rem_r) >= need;
    st.div_done     = div_done;
  end

  assign envelope_level = out_level_r;
  assign envelope_phase = out_phase_r;

endmodule

// ===== design/triggered_ahr_envelope.sv =====
// ----------------------------------------------------------------------------
// triggered_ahr_envelope
// attack/hold/release envelope driven by timed ticks and event ids
//
// usage
//   input channel: one beat per tick with in_tick_delta, in_event_valid and
//   in_event_id; taken when in_valid is high and in_stall low
//   result channel: one beat per tick with out_envelope_level and
//   out_envelope_phase, held in an output register until taken
//   config: APB write of attack (0x0), hold (0x4), release (0x8) times
//   sequencing: a tick is loaded, then each segment is walked in order; a
//   zero-length or hold segment is stepped, a timed attack or release
//   segment is multiplied out and checked, and when a segment ends mid-way
//   the bit-serial divider runs, which sets the worst case
//   throughput: one tick at a time; in_stall stays high from acceptance
//   until the result is loaded into the output register
//   a stalled receiver holds the result; the next tick may be taken and
//   worked on meanwhile, and waits in the last step for the register
//   reset: phase idle, level zero, no event seen, registers at defaults
// ----------------------------------------------------------------------------
module triggered_ahr_envelope #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tahr_pkg::DELTA_W-1:0]   in_tick_delta,
  input  logic                           in_event_valid,
  input  logic [tahr_pkg::EVENT_W-1:0]   in_event_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [FRAC_BITS:0]             out_envelope_level,
  output logic [1:0]                     out_envelope_phase,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tahr_pkg::ADDR_W-1:0]    paddr,
  input  logic [tahr_pkg::DATA_W-1:0]    pwdata,
  output logic [tahr_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int TW = tahr_pkg::TIME_W;

  logic [TW-1:0]     attack_time_r, attack_time_nxt;
  logic [TW-1:0]     hold_time_r, hold_time_nxt;
  logic [TW-1:0]     release_time_r, release_time_nxt;
  logic              wr_en;
  logic [1:0]        reg_idx;
  tahr_pkg::cmd_t    cmd;
  tahr_pkg::status_t st;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    attack_time_nxt  = attack_time_r;
    hold_time_nxt    = hold_time_r;
    release_time_nxt = release_time_r;
    if (wr_en) begin
      unique case (reg_idx)
        tahr_pkg::REG_ATTACK:  attack_time_nxt  = pwdata[TW-1:0];
        tahr_pkg::REG_HOLD:    hold_time_nxt    = pwdata[TW-1:0];
        tahr_pkg::REG_RELEASE: release_time_nxt = pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tahr_pkg::REG_ATTACK:  prdata = tahr_pkg::DATA_W'(attack_time_r);
      tahr_pkg::REG_HOLD:    prdata = tahr_pkg::DATA_W'(hold_time_r);
      tahr_pkg::REG_RELEASE: prdata = tahr_pkg::DATA_W'(release_time_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_time_r  <= tahr_pkg::ATTACK_RST;
      hold_time_r    <= tahr_pkg::HOLD_RST;
      release_time_r <= tahr_pkg::RELEASE_RST;
    end else begin
      attack_time_r  <= attack_time_nxt;
      hold_time_r    <= hold_time_nxt;
      release_time_r <= release_time_nxt;
    end
  end

  tahr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  tahr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .attack_time    (attack_time_r),
    .hold_time      (hold_time_r),
    .release_time   (release_time_r),
    .tick_delta     (in_tick_delta),
    .event_valid    (in_event_valid),
    .event_id       (in_event_id),
    .envelope_level (out_envelope_level),
    .envelope_phase (out_envelope_phase)
  );

endmodule
